>>> rtl/rse_pkg.sv
// Shared constants, types and register codes of the rotor state estimator.
// Used by rse_window, rse_velocity_filter and rotor_state_estimator.
// No dependencies.
package rse_pkg;

    // Field widths
    localparam int ENCODER_BITS = 14;
    localparam int SAMPLE_BITS  = 12;
    localparam int TURN_BITS    = 32;
    localparam int POS_BITS     = TURN_BITS + ENCODER_BITS;
    localparam int VEL_BITS     = 32;
    localparam int ALPHA_BITS   = 16;
    localparam int MEAN_BITS    = SAMPLE_BITS + 1;

    // Moving window: the depth must be a power of two, the mean is a shift
    localparam int WINDOW_DEPTH = 16;
    localparam int WINDOW_LOG   = $clog2(WINDOW_DEPTH);
    localparam int SLOT_BITS    = WINDOW_LOG;
    localparam int SUM_BITS     = SAMPLE_BITS + WINDOW_LOG;

    // Unwrap and velocity step limits
    localparam int HALF_TURN    = 1 << (ENCODER_BITS - 1);
    localparam int STEP_BITS    = 16;
    localparam int STEP_LIMIT   = 32767;

    // Configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // Stream payload layouts
    localparam int IN_FIELD_BITS  = ENCODER_BITS + 4 * SAMPLE_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = TURN_BITS + POS_BITS + 2 * VEL_BITS
                                    + 3 * MEAN_BITS + SAMPLE_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // Register reset values
    localparam logic [ENCODER_BITS-1:0] POS_OFFSET_RST  = '0;
    localparam logic [ALPHA_BITS-1:0]   FAST_ALPHA_RST  = 16'd65535;
    localparam logic [ALPHA_BITS-1:0]   SLOW_ALPHA_RST  = 16'd6554;
    localparam logic [SAMPLE_BITS-1:0]  PHASE_OFF_RST   = SAMPLE_BITS'(2048);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_POS_OFFSET = 3'd0,
        CFG_FAST_ALPHA = 3'd1,
        CFG_SLOW_ALPHA = 3'd2,
        CFG_PHASE_A    = 3'd3,
        CFG_PHASE_B    = 3'd4,
        CFG_PHASE_C    = 3'd5
    } t_cfg_reg;

    // Control shared by the four window channels
    typedef struct packed {
        logic                 en;
        logic                 full;
        logic [SLOT_BITS-1:0] slot;
    } t_win_ctrl;

endpackage

>>> rtl/rse_window.sv
// One moving-window channel: sample ring and running sum.
// Depends on rse_pkg.
module rse_window
    import rse_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_win_ctrl              i_ctrl,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic [SUM_BITS-1:0]    o_sum
);

    logic [SAMPLE_BITS-1:0] r_ring [WINDOW_DEPTH];
    logic [SUM_BITS-1:0]    r_sum;
    logic [SUM_BITS-1:0]    n_sum;
    logic [SAMPLE_BITS-1:0] old_sample;

    // ring slots are only read back once every slot has been written
    assign old_sample = i_ctrl.full ? r_ring[i_ctrl.slot] : '0;
    assign n_sum      = r_sum - SUM_BITS'(old_sample) + SUM_BITS'(i_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctrl.en) begin
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_ring[i_ctrl.slot] <= i_sample;
        end
    end

    assign o_sum = r_sum;

endmodule

>>> rtl/rse_velocity_filter.sv
// Exponential velocity filter in Q15.16 with round-half-up.
// Depends on rse_pkg.
module rse_velocity_filter
    import rse_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic signed [STEP_BITS-1:0]  i_step,
    input  logic        [ALPHA_BITS-1:0] i_alpha,
    output logic signed [VEL_BITS-1:0]   o_vel
);

    localparam int DELTA_BITS = VEL_BITS + 1;
    localparam int PROD_BITS  = DELTA_BITS + ALPHA_BITS + 1;

    logic signed [VEL_BITS-1:0]   r_vel;
    logic signed [VEL_BITS-1:0]   target;
    logic signed [DELTA_BITS-1:0] delta;
    logic signed [PROD_BITS-1:0]  prod;
    logic signed [PROD_BITS-1:0]  rounded;
    logic signed [VEL_BITS-1:0]   n_vel;

    // v' = v + round((alpha * (u - v)) / 2^16), u = step in Q15.16
    assign target  = {i_step, {(VEL_BITS - STEP_BITS){1'b0}}};
    assign delta   = DELTA_BITS'(target) - DELTA_BITS'(r_vel);
    assign prod    = $signed({1'b0, i_alpha}) * delta;
    assign rounded = (prod + PROD_BITS'(1 << (ALPHA_BITS - 1))) >>> ALPHA_BITS;
    assign n_vel   = r_vel + rounded[VEL_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel <= '0;
        end else if (i_en) begin
            r_vel <= n_vel;
        end
    end

    assign o_vel = r_vel;

endmodule

>>> rtl/rotor_state_estimator.sv
// Rotor state estimator top level: encoder unwrap, velocity filters, window means.
// Depends on rse_pkg, rse_window and rse_velocity_filter.
//
// Usage:
//  - One transfer on s_axis per control tick: encoder reading and four ADC
//    samples (phase A, B, C currents and supply). One result transfer on
//    m_axis per input transfer, in order; tlast marks the tick at which the
//    window slot index wrapped back to slot zero.
//  - Settings go in over the cfg channel (index, data); it is always ready.
//    Write only while no tick is in flight.
//  - Three register stages: input, unwrap/window, velocity/means. A result
//    is offered on m_axis once its tick has passed through all three, and
//    one tick per cycle is sustained while m_axis is ready; the velocity
//    filter feedback (one multiply and add per filter) sets the cycle.
//  - Reset clears the turn count, position, filters, window sums and slot
//    index and loads the register defaults. Ring contents need no reset:
//    they are not read until every slot has been written once.
//  - When m_axis stalls, empty stages keep filling, so up to three ticks
//    are taken before s_axis_tready drops; nothing is lost or repeated.
module rotor_state_estimator
    import rse_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration write channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    // input stream
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // encoder_angle, current_a_sample, current_b_sample, current_c_sample,
    // supply_sample
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    // output stream
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // turn_count, rotor_position, fast_velocity, slow_velocity,
    // mean_current_a, mean_current_b, mean_current_c, mean_supply
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    output logic                     m_axis_tlast   // window_done
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ENCODER_BITS-1:0] r_pos_offset;
    logic [ALPHA_BITS-1:0]   r_fast_alpha;
    logic [ALPHA_BITS-1:0]   r_slow_alpha;
    logic [SAMPLE_BITS-1:0]  r_phase_off [3];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_offset   <= POS_OFFSET_RST;
            r_fast_alpha   <= FAST_ALPHA_RST;
            r_slow_alpha   <= SLOW_ALPHA_RST;
            r_phase_off[0] <= PHASE_OFF_RST;
            r_phase_off[1] <= PHASE_OFF_RST;
            r_phase_off[2] <= PHASE_OFF_RST;
        end else if (i_cfg_valid) begin
            // indices past the list are dropped
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_POS_OFFSET: r_pos_offset   <= i_cfg_data[ENCODER_BITS-1:0];
                CFG_FAST_ALPHA: r_fast_alpha   <= i_cfg_data[ALPHA_BITS-1:0];
                CFG_SLOW_ALPHA: r_slow_alpha   <= i_cfg_data[ALPHA_BITS-1:0];
                CFG_PHASE_A:    r_phase_off[0] <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_PHASE_B:    r_phase_off[1] <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_PHASE_C:    r_phase_off[2] <= i_cfg_data[SAMPLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: each stage advances when the one after it
    // moves or is empty, so bubbles collapse under a stalled output.
    // ------------------------------------------------------------------
    logic r_s1_valid;
    logic r_s2_valid;
    logic r_out_valid;
    logic adv_out;
    logic adv_s2;
    logic adv_s1;

    assign adv_out       = !r_out_valid || m_axis_tready;
    assign adv_s2        = adv_out || !r_s2_valid;
    assign adv_s1        = adv_s2 || !r_s1_valid;
    assign s_axis_tready = adv_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv_s1) begin
                r_s1_valid <= s_axis_tvalid;
            end
            if (adv_s2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (adv_out) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic [ENCODER_BITS-1:0] r_s1_enc;
    logic [SAMPLE_BITS-1:0]  r_s1_sample [4];

    always_ff @(posedge i_clk) begin
        if (adv_s1) begin
            r_s1_enc <= s_axis_tdata[ENCODER_BITS-1:0];
            for (int k = 0; k < 4; k++) begin
                r_s1_sample[k] <= s_axis_tdata[ENCODER_BITS + k*SAMPLE_BITS +: SAMPLE_BITS];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: unwrap, position, saturated step, window update
    // ------------------------------------------------------------------
    logic                       upd_s2;
    logic [ENCODER_BITS-1:0]    r_last_enc;
    logic [TURN_BITS-1:0]       r_turns;
    logic [POS_BITS-1:0]        r_last_pos;
    logic [SLOT_BITS-1:0]       r_slot;
    logic                       r_full;
    logic signed [STEP_BITS-1:0] r_s2_step;
    logic                       r_s2_done;

    logic signed [ENCODER_BITS:0] enc_diff;
    logic [TURN_BITS-1:0]         n_turns;
    logic [POS_BITS-1:0]          n_pos;
    logic signed [POS_BITS:0]     pos_diff;
    logic signed [STEP_BITS-1:0]  n_step;
    logic [SLOT_BITS-1:0]         n_slot;
    logic                         slot_wrap;

    assign upd_s2 = r_s1_valid && adv_s2;

    assign enc_diff = $signed({1'b0, r_s1_enc}) - $signed({1'b0, r_last_enc});

    // a jump of more than half a turn counts a revolution; exactly half does not
    always_comb begin
        priority if (enc_diff < -(ENCODER_BITS + 1)'(HALF_TURN)) begin
            n_turns = r_turns + TURN_BITS'(1);
        end else if (enc_diff > (ENCODER_BITS + 1)'(HALF_TURN)) begin
            n_turns = r_turns - TURN_BITS'(1);
        end else begin
            n_turns = r_turns;
        end
    end

    assign n_pos    = {n_turns, r_s1_enc} - POS_BITS'(r_pos_offset);
    assign pos_diff = $signed({n_pos[POS_BITS-1], n_pos})
                      - $signed({r_last_pos[POS_BITS-1], r_last_pos});

    // clamp the position step to +-STEP_LIMIT ticks
    always_comb begin
        priority if (pos_diff > (POS_BITS + 1)'(STEP_LIMIT)) begin
            n_step = STEP_BITS'(STEP_LIMIT);
        end else if (pos_diff < -(POS_BITS + 1)'(STEP_LIMIT)) begin
            n_step = -STEP_BITS'(STEP_LIMIT);
        end else begin
            n_step = pos_diff[STEP_BITS-1:0];
        end
    end

    assign slot_wrap = (r_slot == SLOT_BITS'(WINDOW_DEPTH - 1));
    assign n_slot    = slot_wrap ? '0 : r_slot + SLOT_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_enc <= '0;
            r_turns    <= '0;
            r_last_pos <= '0;
            r_slot     <= '0;
            r_full     <= 1'b0;
        end else if (upd_s2) begin
            r_last_enc <= r_s1_enc;
            r_turns    <= n_turns;
            r_last_pos <= n_pos;
            r_slot     <= n_slot;
            if (slot_wrap) begin
                r_full <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_s2) begin
            r_s2_step <= n_step;
            r_s2_done <= slot_wrap;
        end
    end

    // window channels: A, B, C, supply
    t_win_ctrl           win_ctrl;
    logic [SUM_BITS-1:0] win_sum [4];

    assign win_ctrl.en   = upd_s2;
    assign win_ctrl.full = r_full;
    assign win_ctrl.slot = r_slot;

    for (genvar g = 0; g < 4; g++) begin : g_window
        rse_window u_window (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (win_ctrl),
            .i_sample (r_s1_sample[g]),
            .o_sum    (win_sum[g])
        );
    end

    // ------------------------------------------------------------------
    // Output stage: velocity filters and window means. The filter state
    // registers double as the velocity fields of the result register.
    // ------------------------------------------------------------------
    logic                       upd_out;
    logic signed [VEL_BITS-1:0] fast_vel;
    logic signed [VEL_BITS-1:0] slow_vel;

    assign upd_out = r_s2_valid && adv_out;

    rse_velocity_filter u_fast_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (upd_out),
        .i_step  (r_s2_step),
        .i_alpha (r_fast_alpha),
        .o_vel   (fast_vel)
    );

    rse_velocity_filter u_slow_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (upd_out),
        .i_step  (r_s2_step),
        .i_alpha (r_slow_alpha),
        .o_vel   (slow_vel)
    );

    logic [TURN_BITS-1:0]   r_out_turns;
    logic [POS_BITS-1:0]    r_out_pos;
    logic [MEAN_BITS-1:0]   r_out_mean [3];
    logic [SAMPLE_BITS-1:0] r_out_supply;
    logic                   r_out_done;

    always_ff @(posedge i_clk) begin
        if (upd_out) begin
            r_out_turns <= r_turns;
            r_out_pos   <= r_last_pos;
            for (int k = 0; k < 3; k++) begin
                // floor of the window mean, then the phase offset
                r_out_mean[k] <= {1'b0, win_sum[k][SUM_BITS-1:WINDOW_LOG]}
                                 - {1'b0, r_phase_off[k]};
            end
            r_out_supply <= win_sum[3][SUM_BITS-1:WINDOW_LOG];
            r_out_done   <= r_s2_done;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_done;
    assign m_axis_tdata  = {
        (OUT_DATA_BITS - OUT_FIELD_BITS)'(0),
        r_out_supply,
        r_out_mean[2],
        r_out_mean[1],
        r_out_mean[0],
        slow_vel,
        fast_vel,
        r_out_pos,
        r_out_turns
    };

endmodule
